@@ src/assert_macros.svh @@
// shared assertion macros, clocked on clk_i with active-low reset rst_ni
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked only outside reset
`define DDPD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// checked at every edge, reset included
`define DDPD_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

@@ src/ddpd_pkg.sv @@
package ddpd_pkg;

  // default fixed point formats
  localparam int unsigned ANGLE_FRAC_BITS_DEF = 7;
  localparam int unsigned GAIN_FRAC_BITS_DEF  = 8;

  // field widths
  localparam int unsigned HEAD_W  = 17;
  localparam int unsigned TIME_W  = 32;
  localparam int unsigned GAIN_W  = 16;
  localparam int unsigned SPEED_W = 7;
  localparam int unsigned SERVO_W = 8;

  // stream and config port widths
  localparam int unsigned S_TDATA_W  = 56;
  localparam int unsigned M_TDATA_W  = 24;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 16;

  // datapath widths: heading error stays within +-65535, so the
  // derivative numerator (error step times 1000) stays below 2^27
  localparam int unsigned ERR_W   = 18;
  localparam int unsigned NUM_W   = 28;
  localparam int unsigned DERR_W  = NUM_W + 1;
  localparam int unsigned P_W     = GAIN_W + 1 + ERR_W;
  localparam int unsigned D_W     = GAIN_W + 1 + DERR_W;
  localparam int unsigned OMEGA_W = D_W + 1;
  localparam int unsigned V_W     = OMEGA_W + 1;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_PROP_GAIN  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DERIV_GAIN = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_SPEED  = 2'd2;

  // reset values
  localparam logic [GAIN_W-1:0]  PROP_GAIN_RST  = 16'd256;
  localparam logic [GAIN_W-1:0]  DERIV_GAIN_RST = 16'd51;
  localparam logic [SPEED_W-1:0] MAX_SPEED_RST  = 7'd25;
  localparam logic [TIME_W-1:0]  STEP_RST       = 32'd10;

  // servo constants
  localparam logic [SERVO_W-1:0] SERVO_CENTER = 8'd90;
  localparam logic [SPEED_W-1:0] SPEED_LIMIT  = 7'd90;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_DIV,
    ST_MUL,
    ST_SUM,
    ST_FIN
  } state_e;

  typedef enum logic [2:0] {
    ZONE_FWD_LO,
    ZONE_FWD_HI,
    ZONE_REAR_R,
    ZONE_REAR_L,
    ZONE_INVALID
  } zone_e;

  typedef struct packed {
    logic in_ready;
    logic div_start;
    logic mul_en;
    logic sum_en;
    logic commit;
  } ctrl_cmd_t;

  typedef struct packed {
    logic fwd;
    logic div_busy;
    logic out_free;
  } ctrl_stat_t;

endpackage

@@ src/diff_drive_pd_heading.sv @@
// Heading controller for a two-wheel differential drive.
// Input stream s_axis: one heading command per transfer (angle in 1/128
// degree, millisecond timestamp). Output stream m_axis: one result per
// command with both servo positions (90 is stop) and the drive enable flag.
// Config channel cfg_*: index 0 proportional gain, 1 derivative gain,
// 2 max wheel speed; always ready, write only while no command is in flight.
// Forward-zone commands run the PD loop through the check, divide, multiply,
// sum and final steps; the divide step is the 28-step bit-serial divider that
// forms the derivative. Rear-zone and invalid commands go from check straight
// to the final step, where the result is written to the output register.
// A result waits in the output register while m_axis_tready is low; the
// next command is still accepted and worked on, and it stalls only at its
// final step until the register frees up.
// Reset restores the register defaults (256, 51, 25), clears the loop
// history (previous step 10 ms) and enables the drive.
module diff_drive_pd_heading #(
  parameter int unsigned ANGLE_FRAC_BITS = ddpd_pkg::ANGLE_FRAC_BITS_DEF,
  parameter int unsigned GAIN_FRAC_BITS  = ddpd_pkg::GAIN_FRAC_BITS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // heading [16:0], now_ms [48:17], zero fill above
  input  logic [ddpd_pkg::S_TDATA_W-1:0]  s_axis_tdata,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // left_servo [7:0], right_servo [15:8], drive_enabled [16], zero fill above
  output logic [ddpd_pkg::M_TDATA_W-1:0]  m_axis_tdata,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [ddpd_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [ddpd_pkg::CFG_DATA_W-1:0] cfg_data_i
);

  ddpd_pkg::ctrl_cmd_t  cmd;
  ddpd_pkg::ctrl_stat_t status;

  ddpd_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  ddpd_dp #(
    .ANGLE_FRAC_BITS (ANGLE_FRAC_BITS),
    .GAIN_FRAC_BITS  (GAIN_FRAC_BITS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .status_o    (status),
    .s_valid_i   (s_axis_tvalid),
    .s_data_i    (s_axis_tdata),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .m_ready_i   (m_axis_tready),
    .m_valid_o   (m_axis_tvalid),
    .m_data_o    (m_axis_tdata)
  );

  assign s_axis_tready = cmd.in_ready;
  assign cfg_ready_o   = 1'b1;

endmodule

@@ src/ddpd_div.sv @@
`include "assert_macros.svh"

// restoring unsigned divider, one quotient bit per cycle
module ddpd_div #(
  parameter int unsigned DIVIDEND_W = ddpd_pkg::NUM_W,
  parameter int unsigned DIVISOR_W  = ddpd_pkg::TIME_W
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  logic [DIVIDEND_W-1:0] dividend_i,
  input  logic [DIVISOR_W-1:0]  divisor_i,
  output logic                  busy_o,
  output logic [DIVIDEND_W-1:0] quotient_o
);

  localparam int unsigned CNT_W = $clog2(DIVIDEND_W + 1);

  logic [CNT_W-1:0]      cnt_q;
  logic [DIVIDEND_W-1:0] quo_q, quo_d;
  logic [DIVISOR_W-1:0]  rem_q, rem_d;
  logic [DIVISOR_W-1:0]  den_q;
  logic [DIVISOR_W:0]    shifted;
  logic [DIVISOR_W:0]    trial;
  logic                  fits;

  // shift in the next dividend bit and try to subtract
  always_comb begin
    shifted = {rem_q, quo_q[DIVIDEND_W-1]};
    trial   = shifted - {1'b0, den_q};
    fits    = ~trial[DIVISOR_W];
    rem_d   = fits ? trial[DIVISOR_W-1:0] : shifted[DIVISOR_W-1:0];
    quo_d   = {quo_q[DIVIDEND_W-2:0], fits};
  end

  // iteration counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (start_i) begin
      cnt_q <= CNT_W'(DIVIDEND_W);
    end else if (busy_o) begin
      cnt_q <= cnt_q - 1'b1;
    end
  end

  // operand and partial remainder registers
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      rem_q <= '0;
      den_q <= divisor_i;
    end else if (busy_o) begin
      quo_q <= quo_d;
      rem_q <= rem_d;
    end
  end

  assign busy_o     = (cnt_q != '0);
  assign quotient_o = quo_q;

  `DDPD_ASSERT(a_div_runs, start_i |=> busy_o, "divider did not start")

endmodule

@@ src/ddpd_ctrl.sv @@
`include "assert_macros.svh"

// sequencer for one heading command at a time
module ddpd_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  input  ddpd_pkg::ctrl_stat_t  status_i,
  output ddpd_pkg::ctrl_cmd_t   cmd_o
);

  ddpd_pkg::state_e state_q, state_d;

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ddpd_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // next state and commands
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      ddpd_pkg::ST_IDLE: begin
        cmd_o.in_ready = 1'b1;
        if (in_valid_i) begin
          state_d = ddpd_pkg::ST_CHECK;
        end
      end
      ddpd_pkg::ST_CHECK: begin
        if (status_i.fwd) begin
          cmd_o.div_start = 1'b1;
          state_d         = ddpd_pkg::ST_DIV;
        end else begin
          state_d = ddpd_pkg::ST_FIN;
        end
      end
      ddpd_pkg::ST_DIV: begin
        if (!status_i.div_busy) begin
          state_d = ddpd_pkg::ST_MUL;
        end
      end
      ddpd_pkg::ST_MUL: begin
        cmd_o.mul_en = 1'b1;
        state_d      = ddpd_pkg::ST_SUM;
      end
      ddpd_pkg::ST_SUM: begin
        cmd_o.sum_en = 1'b1;
        state_d      = ddpd_pkg::ST_FIN;
      end
      ddpd_pkg::ST_FIN: begin
        if (status_i.out_free) begin
          cmd_o.commit = 1'b1;
          state_d      = ddpd_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = ddpd_pkg::ST_IDLE;
      end
    endcase
  end

  `DDPD_ASSERT(a_commit_free, cmd_o.commit |-> status_i.out_free, "commit over a held result")
  `DDPD_ASSERT(a_div_wait, (state_q == ddpd_pkg::ST_DIV && status_i.div_busy) |=> (state_q == ddpd_pkg::ST_DIV), "left divide early")
  `DDPD_ASSERT_RST(a_rst_idle, !rst_ni |=> (state_q == ddpd_pkg::ST_IDLE), "not idle in reset")

endmodule

@@ src/ddpd_dp.sv @@
`include "assert_macros.svh"

// registers, zone decode, PD arithmetic and the output register
module ddpd_dp #(
  parameter int unsigned ANGLE_FRAC_BITS = ddpd_pkg::ANGLE_FRAC_BITS_DEF,
  parameter int unsigned GAIN_FRAC_BITS  = ddpd_pkg::GAIN_FRAC_BITS_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  ddpd_pkg::ctrl_cmd_t                 cmd_i,
  output ddpd_pkg::ctrl_stat_t                status_o,
  input  logic                                s_valid_i,
  input  logic [ddpd_pkg::S_TDATA_W-1:0]      s_data_i,
  input  logic                                cfg_valid_i,
  input  logic [ddpd_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [ddpd_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  input  logic                                m_ready_i,
  output logic                                m_valid_o,
  output logic [ddpd_pkg::M_TDATA_W-1:0]      m_data_o
);

  localparam int unsigned HEAD_W  = ddpd_pkg::HEAD_W;
  localparam int unsigned TIME_W  = ddpd_pkg::TIME_W;
  localparam int unsigned ERR_W   = ddpd_pkg::ERR_W;
  localparam int unsigned NUM_W   = ddpd_pkg::NUM_W;
  localparam int unsigned DERR_W  = ddpd_pkg::DERR_W;
  localparam int unsigned V_W     = ddpd_pkg::V_W;
  localparam int unsigned SERVO_W = ddpd_pkg::SERVO_W;
  localparam int unsigned FB      = ANGLE_FRAC_BITS + GAIN_FRAC_BITS;
  // 360 degrees need ANGLE_FRAC_BITS + 9 bits plus sign
  localparam int unsigned CMP_W   = (ANGLE_FRAC_BITS + 10 > ERR_W) ? ANGLE_FRAC_BITS + 10 : ERR_W;
  localparam int unsigned PAD_W   = ddpd_pkg::M_TDATA_W - 2 * SERVO_W - 1;

  localparam logic signed [CMP_W-1:0] A90  = CMP_W'(90 * (2 ** ANGLE_FRAC_BITS));
  localparam logic signed [CMP_W-1:0] A180 = CMP_W'(180 * (2 ** ANGLE_FRAC_BITS));
  localparam logic signed [CMP_W-1:0] A270 = CMP_W'(270 * (2 ** ANGLE_FRAC_BITS));
  localparam logic signed [CMP_W-1:0] A360 = CMP_W'(360 * (2 ** ANGLE_FRAC_BITS));

  // captured command
  logic signed [HEAD_W-1:0]           head_q;
  logic [TIME_W-1:0]                  now_q;

  // configuration
  logic [ddpd_pkg::GAIN_W-1:0]        prop_gain_q;
  logic [ddpd_pkg::GAIN_W-1:0]        deriv_gain_q;
  logic [ddpd_pkg::SPEED_W-1:0]       max_speed_q;

  // loop state
  logic signed [ERR_W-1:0]            prev_error_q;
  logic [TIME_W-1:0]                  prev_step_q;
  logic [TIME_W-1:0]                  last_time_q;
  logic                               attached_q, attached_d;

  // arithmetic
  logic signed [CMP_W-1:0]            h_ext;
  logic signed [CMP_W-1:0]            err_wide;
  logic signed [ERR_W-1:0]            err;
  logic signed [ERR_W:0]              err_step;
  logic signed [DERR_W-1:0]           num_s;
  logic [NUM_W-1:0]                   num_mag;
  logic [TIME_W-1:0]                  divisor;
  logic [NUM_W-1:0]                   quotient;
  logic                               div_busy;
  logic                               neg_q;
  logic signed [DERR_W-1:0]           derr;
  logic signed [ddpd_pkg::P_W-1:0]    pterm_d, pterm_q;
  logic signed [ddpd_pkg::D_W-1:0]    dterm_d, dterm_q;
  logic signed [ddpd_pkg::OMEGA_W-1:0] omega_d, omega_q;
  logic [ddpd_pkg::SPEED_W-1:0]       lim;
  logic signed [V_W-1:0]              lwf;
  logic signed [V_W-1:0]              v;
  logic signed [V_W-1:0]              clamped;
  logic signed [V_W-1:0]              shifted;
  logic [SERVO_W-1:0]                 wheel, wheel_lo, wheel_hi;
  logic [SERVO_W-1:0]                 left, right;
  ddpd_pkg::zone_e                    zone;
  logic                               reenable;
  logic                               fwd;

  logic                               m_valid_q;
  logic [ddpd_pkg::M_TDATA_W-1:0]     m_data_q;

  // command capture
  always_ff @(posedge clk_i) begin
    if (s_valid_i && cmd_i.in_ready) begin
      head_q <= s_data_i[HEAD_W-1:0];
      now_q  <= s_data_i[HEAD_W+TIME_W-1:HEAD_W];
    end
  end

  // zone decode
  assign h_ext = CMP_W'(head_q);

  always_comb begin
    priority if (h_ext < 0) begin
      zone = ddpd_pkg::ZONE_INVALID;
    end else if (h_ext <= A90) begin
      zone = ddpd_pkg::ZONE_FWD_LO;
    end else if (h_ext <= A180) begin
      zone = ddpd_pkg::ZONE_REAR_R;
    end else if (h_ext < A270) begin
      zone = ddpd_pkg::ZONE_REAR_L;
    end else if (h_ext == A270) begin
      zone = ddpd_pkg::ZONE_INVALID;
    end else begin
      zone = ddpd_pkg::ZONE_FWD_HI;
    end
  end

  assign fwd      = (zone == ddpd_pkg::ZONE_FWD_LO) || (zone == ddpd_pkg::ZONE_FWD_HI);
  assign reenable = (h_ext >= 0) && (h_ext < A360);

  // heading error and derivative numerator (times 1000 as shifts)
  always_comb begin
    err_wide = (h_ext > A180) ? (h_ext - A360) : h_ext;
    err      = err_wide[ERR_W-1:0];
    err_step = (ERR_W+1)'(err) - (ERR_W+1)'(prev_error_q);
    num_s    = (DERR_W'(err_step) <<< 10) - (DERR_W'(err_step) <<< 4)
             - (DERR_W'(err_step) <<< 3);
    num_mag  = num_s[DERR_W-1] ? NUM_W'(-num_s) : NUM_W'(num_s);
    divisor  = (prev_step_q == '0) ? TIME_W'(1) : prev_step_q;
  end

  ddpd_div #(
    .DIVIDEND_W (NUM_W),
    .DIVISOR_W  (TIME_W)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (num_mag),
    .divisor_i  (divisor),
    .busy_o     (div_busy),
    .quotient_o (quotient)
  );

  // numerator sign for the truncating quotient
  always_ff @(posedge clk_i) begin
    if (cmd_i.div_start) begin
      neg_q <= num_s[DERR_W-1];
    end
  end

  // derivative never exceeds 2^27, so it fits the signed DERR_W-bit derr without saturation
  assign derr = neg_q ? -$signed({1'b0, quotient}) : $signed({1'b0, quotient});

  // gain products, then their sum
  assign pterm_d = $signed({1'b0, prop_gain_q}) * err;
  assign dterm_d = $signed({1'b0, deriv_gain_q}) * derr;
  assign omega_d = ddpd_pkg::OMEGA_W'(pterm_q) + ddpd_pkg::OMEGA_W'(dterm_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul_en) begin
      pterm_q <= pterm_d;
      dterm_q <= dterm_d;
    end
    if (cmd_i.sum_en) begin
      omega_q <= omega_d;
    end
  end

  // clamp the loop output and turn it into a servo position
  always_comb begin
    lim      = (max_speed_q > ddpd_pkg::SPEED_LIMIT) ? ddpd_pkg::SPEED_LIMIT : max_speed_q;
    lwf      = V_W'($signed({1'b0, lim})) <<< FB;
    v        = ((zone == ddpd_pkg::ZONE_FWD_LO) ? lwf : -lwf) - V_W'(omega_q);
    if (v < -lwf) begin
      clamped = -lwf;
    end else if (v > lwf) begin
      clamped = lwf;
    end else begin
      clamped = v;
    end
    shifted  = clamped >>> FB;
    wheel    = ddpd_pkg::SERVO_CENTER + shifted[SERVO_W-1:0];
    wheel_lo = ddpd_pkg::SERVO_CENTER - {1'b0, lim};
    wheel_hi = ddpd_pkg::SERVO_CENTER + {1'b0, lim};
  end

  // result select per zone
  always_comb begin
    attached_d = attached_q;
    unique case (zone)
      ddpd_pkg::ZONE_FWD_LO: begin
        left  = wheel;
        right = wheel_lo;
      end
      ddpd_pkg::ZONE_FWD_HI: begin
        left  = wheel_hi;
        right = wheel;
      end
      ddpd_pkg::ZONE_REAR_R: begin
        left  = wheel_lo;
        right = wheel_lo;
      end
      ddpd_pkg::ZONE_REAR_L: begin
        left  = wheel_hi;
        right = wheel_hi;
      end
      default: begin
        left  = ddpd_pkg::SERVO_CENTER;
        right = ddpd_pkg::SERVO_CENTER;
      end
    endcase
    if (zone == ddpd_pkg::ZONE_INVALID) begin
      attached_d = 1'b0;
    end else if (reenable) begin
      attached_d = 1'b1;
    end
  end

  // configuration and loop state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prop_gain_q  <= ddpd_pkg::PROP_GAIN_RST;
      deriv_gain_q <= ddpd_pkg::DERIV_GAIN_RST;
      max_speed_q  <= ddpd_pkg::MAX_SPEED_RST;
      prev_error_q <= '0;
      prev_step_q  <= ddpd_pkg::STEP_RST;
      last_time_q  <= '0;
      attached_q   <= 1'b1;
      m_valid_q    <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        unique case (cfg_index_i)
          ddpd_pkg::REG_PROP_GAIN:  prop_gain_q  <= cfg_data_i;
          ddpd_pkg::REG_DERIV_GAIN: deriv_gain_q <= cfg_data_i;
          ddpd_pkg::REG_MAX_SPEED:  max_speed_q  <= cfg_data_i[ddpd_pkg::SPEED_W-1:0];
          default: ;
        endcase
      end
      if (cmd_i.commit) begin
        attached_q <= attached_d;
        if (fwd) begin
          prev_step_q  <= now_q - last_time_q;
          last_time_q  <= now_q;
          prev_error_q <= err;
        end
      end
      if (cmd_i.commit) begin
        m_valid_q <= 1'b1;
      end else if (m_ready_i) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  // output register
  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      m_data_q <= {PAD_W'(0), attached_d, right, left};
    end
  end

  assign m_valid_o         = m_valid_q;
  assign m_data_o          = m_data_q;
  assign status_o.fwd      = fwd;
  assign status_o.div_busy = div_busy;
  assign status_o.out_free = !m_valid_q || m_ready_i;

  `DDPD_ASSERT(a_disable, (cmd_i.commit && zone == ddpd_pkg::ZONE_INVALID) |=> !attached_q, "invalid angle left drive enabled")

endmodule
